[sv/oac_pkg.sv]
// Shared types and constants for the obstacle avoidance controller.
// No dependencies; imported by oac_core and obstacle_avoidance_controller_unit.
package oac_pkg;

  typedef logic signed [8:0] cmd_t;
  typedef logic [15:0]       range_t;
  typedef logic [8:0]        heading_t;
  typedef logic signed [10:0] hdiff_t;

  typedef enum logic [1:0] {
    ACT_SPEED = 2'd0,
    ACT_ANGLE = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  typedef enum logic {
    CFG_SAFE = 1'b0,
    CFG_STOP = 1'b1
  } cfg_reg_t;

  localparam range_t   SAFE_RESET  = 16'd0;
  localparam range_t   STOP_RESET  = 16'd400;
  localparam hdiff_t   HEAD_AVOID  = 11'sd45;
  localparam hdiff_t   HEAD_TOL    = 11'sd2;
  localparam cmd_t     STEER_RIGHT = 9'sd90;
  localparam cmd_t     STEER_LEFT  = -9'sd90;

  typedef struct packed {
    action_t  action;
    cmd_t     command_value;
    range_t   front_range;
    range_t   left_front_range;
    range_t   right_front_range;
    range_t   rear_range;
    heading_t compass_heading;
  } item_t;

  typedef struct packed {
    logic collision_flag;
    logic obstacle_flag;
    cmd_t angle_command;
    logic angle_issued;
    cmd_t speed_command;
    logic speed_issued;
  } result_t;

  typedef struct packed {
    cmd_t     wanted_speed;
    cmd_t     applied_speed;
    cmd_t     wanted_angle;
    cmd_t     applied_angle;
    heading_t reference_heading;
    logic     avoiding_obstacle;
    logic     avoiding_collision;
    logic     veered_right;
    logic     veered_left;
  } state_t;

endpackage

[sv/oac_core.sv]
// Per-request decision logic: next controller state and result from one request.
// Depends on oac_pkg.
module oac_core
  import oac_pkg::*;
(
  input  state_t  st,
  input  item_t   item,
  input  range_t  safe_distance,
  input  range_t  stop_distance,
  output state_t  st_nxt,
  output result_t res
);

  logic   right_free;
  logic   left_free;
  logic   rear_free;
  hdiff_t moved;
  hdiff_t moved_r;
  hdiff_t moved_l;
  range_t halt_range;

  always_comb begin
    right_free = (item.right_front_range == '0) || (item.right_front_range >= safe_distance);
    left_free  = (item.left_front_range == '0) || (item.left_front_range >= safe_distance);
    rear_free  = (item.rear_range == '0) || (item.rear_range >= safe_distance);
    moved   = $signed({2'b00, item.compass_heading}) - $signed({2'b00, st.reference_heading});
    // a fresh veer resets the reference first, so it has not moved yet
    moved_r = st.veered_right ? moved : '0;
    moved_l = st.veered_left ? moved : '0;
    halt_range = (st.wanted_speed >= 0) ? item.front_range : item.rear_range;

    st_nxt = st;
    res    = '0;

    case (item.action)
      ACT_SPEED: begin
        st_nxt.wanted_speed = item.command_value;
      end
      ACT_ANGLE: begin
        st_nxt.wanted_angle = item.command_value;
        if (!st.avoiding_obstacle) begin
          res.angle_issued     = 1'b1;
          res.angle_command    = item.command_value;
          st_nxt.applied_angle = item.command_value;
        end
      end
      ACT_TICK: begin
        if (st.applied_speed > 0) begin
          if (item.front_range < safe_distance) begin
            if (right_free) begin
              st_nxt.veered_right = 1'b1;
              if (!st.veered_right) begin
                st_nxt.avoiding_obstacle = 1'b1;
                st_nxt.reference_heading = item.compass_heading;
              end
              if (HEAD_AVOID > moved_r + HEAD_TOL) begin
                res.angle_issued  = 1'b1;
                res.angle_command = STEER_RIGHT;
              end else begin
                st_nxt.reference_heading = item.compass_heading;
                st_nxt.avoiding_obstacle = 1'b0;
              end
            end else if (left_free) begin
              st_nxt.veered_left = 1'b1;
              if (!st.veered_left) begin
                st_nxt.avoiding_obstacle = 1'b1;
                st_nxt.reference_heading = item.compass_heading;
              end
              if (-HEAD_AVOID < moved_l - HEAD_TOL) begin
                res.angle_issued  = 1'b1;
                res.angle_command = STEER_LEFT;
              end else begin
                st_nxt.reference_heading = item.compass_heading;
                st_nxt.avoiding_obstacle = 1'b0;
              end
            end else begin
              st_nxt.avoiding_obstacle = 1'b0;
              st_nxt.veered_right      = 1'b0;
              st_nxt.veered_left       = 1'b0;
            end
          end else if (st.veered_right) begin
            if (left_free) begin
              st_nxt.reference_heading = item.compass_heading;
              res.angle_issued         = 1'b1;
              res.angle_command        = STEER_LEFT;
              st_nxt.veered_right      = 1'b0;
            end
            st_nxt.avoiding_obstacle = 1'b0;
          end else if (st.veered_left) begin
            if (right_free) begin
              st_nxt.reference_heading = item.compass_heading;
              res.angle_issued         = 1'b1;
              res.angle_command        = STEER_RIGHT;
              st_nxt.veered_left       = 1'b0;
            end
            st_nxt.avoiding_obstacle = 1'b0;
          end
        end else if (st.applied_speed < 0) begin
          st_nxt.avoiding_obstacle = !rear_free;
          if (st.veered_right) st_nxt.veered_right = 1'b0;
          else                 st_nxt.veered_left  = 1'b0;
          if (st.applied_angle != st.wanted_angle) begin
            res.angle_issued    = 1'b1;
            res.angle_command   = st.applied_angle;
            st_nxt.wanted_angle = st.applied_angle;
          end
        end else begin
          st_nxt.avoiding_obstacle = 1'b0;
        end

        // halt check; repeating it within one tick changes nothing
        if ((halt_range < stop_distance) && (halt_range != '0)) begin
          res.speed_issued          = 1'b1;
          res.speed_command         = '0;
          st_nxt.applied_speed      = '0;
          st_nxt.avoiding_collision = 1'b1;
        end else if (st.applied_speed != st.wanted_speed) begin
          res.speed_issued          = 1'b1;
          res.speed_command         = st.wanted_speed;
          st_nxt.applied_speed      = st.wanted_speed;
          st_nxt.avoiding_collision = 1'b0;
        end
      end
      default: begin
      end
    endcase

    res.obstacle_flag  = st_nxt.avoiding_obstacle;
    res.collision_flag = st_nxt.avoiding_collision;
  end

endmodule

[sv/obstacle_avoidance_controller_unit.sv]
// Top level of the obstacle avoidance controller: stream ports, config registers,
// input and result registers. Depends on oac_pkg and oac_core.
//
// One request in, one result out. A request is taken into an input register and
// decided against the controller state once the output register is free or its
// result is being taken; the state is updated in that same cycle and the result
// lands in an output register. A new request can be taken every cycle while the
// sink takes results. in_tready drops only when both the input and the output
// registers hold data the sink has not taken. Configuration writes are always
// taken (cfg_ready is high) and should be made while the block is idle.
module obstacle_avoidance_controller_unit
  import oac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // command_value[8:0], front_range[24:9],
                                  // left_front_range[40:25], right_front_range[56:41],
                                  // rear_range[72:57], compass_heading[81:73], zero pad
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // speed_issued[0], speed_command[9:1],
                                  // angle_issued[10], angle_command[19:11],
                                  // obstacle_flag[20], collision_flag[21], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_item_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  range_t  safe_r;
  range_t  stop_r;
  item_t   in_item;
  logic    advance;

  assign in_item = '{
    action:            action_t'(in_tuser),
    command_value:     in_tdata[8:0],
    front_range:       in_tdata[24:9],
    left_front_range:  in_tdata[40:25],
    right_front_range: in_tdata[56:41],
    rear_range:        in_tdata[72:57],
    compass_heading:   in_tdata[81:73]
  };

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  oac_core u_core (
    .st            (state_r),
    .item          (s1_item_r),
    .safe_distance (safe_r),
    .stop_distance (stop_r),
    .st_nxt        (state_nxt),
    .res           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      safe_r <= SAFE_RESET;
      stop_r <= STOP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SAFE: safe_r <= cfg_data;
        CFG_STOP: stop_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_tvalid && in_tready) s1_valid_r <= 1'b1;
      else if (advance)           s1_valid_r <= 1'b0;
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) s1_item_r <= in_item;
    if (advance)                out_item_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_item_r};

endmodule

[sim/obstacle_avoidance_controller_unit_checker.sv]
`timescale 1ns / 1ps
// Checker for obstacle_avoidance_controller_unit: watches the request, result and config
// channels, predicts each result from its own controller model and compares field by field.
// Depends on oac_pkg.
module obstacle_avoidance_controller_unit_checker
  import oac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [87:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          outstanding,
  output int          mismatches
);

  range_t   safe_mm;
  range_t   stop_mm;
  cmd_t     want_speed;
  cmd_t     drive_speed;
  cmd_t     want_angle;
  cmd_t     steer_angle;
  heading_t ref_heading;
  logic     avoiding;
  logic     halted;
  logic     went_right;
  logic     went_left;
  result_t  issued;
  result_t  expected_results[$];
  int       error_total = 0;

  function automatic logic side_clear(range_t r);
    return (r == '0) || (r >= safe_mm);
  endfunction

  function automatic void put_speed(cmd_t v);
    issued.speed_issued  = 1'b1;
    issued.speed_command = v;
  endfunction

  function automatic void put_angle(cmd_t v);
    issued.angle_issued  = 1'b1;
    issued.angle_command = v;
  endfunction

  // halt on a close echo in the direction of travel, else apply the wanted speed
  function automatic void stop_or_apply(range_t front, range_t rear);
    range_t d;
    d = (want_speed >= 0) ? front : rear;
    if (d < stop_mm && d != '0) begin
      put_speed('0);
      drive_speed = '0;
      halted      = 1'b1;
    end else if (drive_speed != want_speed) begin
      put_speed(want_speed);
      drive_speed = want_speed;
      halted      = 1'b0;
    end
  endfunction

  // heading change is taken without wrap at 360
  function automatic void steer_toward(int target, heading_t hd);
    int moved;
    moved = int'(hd) - int'(ref_heading);
    if (target < 0 && target < moved - HEAD_TOL) begin
      put_angle(STEER_LEFT);
    end else if (target > 0 && target > moved + HEAD_TOL) begin
      put_angle(STEER_RIGHT);
    end else begin
      ref_heading = hd;
      avoiding    = 1'b0;
    end
  endfunction

  function automatic void control_tick(range_t front, range_t left, range_t right,
                                       range_t rear, heading_t hd);
    if (drive_speed > 0) begin
      // a zero front reading counts as blocked here unless safe_mm is zero
      if (front < safe_mm) begin
        if (side_clear(right)) begin
          if (!went_right) begin
            went_right  = 1'b1;
            avoiding    = 1'b1;
            ref_heading = hd;
          end
          steer_toward(int'(HEAD_AVOID), hd);
        end else if (side_clear(left)) begin
          if (!went_left) begin
            went_left   = 1'b1;
            avoiding    = 1'b1;
            ref_heading = hd;
          end
          steer_toward(-int'(HEAD_AVOID), hd);
        end else begin
          avoiding   = 1'b0;
          went_right = 1'b0;
          went_left  = 1'b0;
          stop_or_apply(front, rear);
        end
      end else if (went_right) begin
        if (side_clear(left)) begin
          ref_heading = hd;
          steer_toward(int'(STEER_LEFT), hd);
          went_right = 1'b0;
        end
        avoiding = 1'b0;
      end else if (went_left) begin
        if (side_clear(right)) begin
          ref_heading = hd;
          steer_toward(int'(STEER_RIGHT), hd);
          went_left = 1'b0;
        end
        avoiding = 1'b0;
      end
    end else if (drive_speed < 0) begin
      if (!side_clear(rear)) begin
        avoiding = 1'b1;
        stop_or_apply(front, rear);
      end else begin
        avoiding = 1'b0;
      end
      if (went_right) went_right = 1'b0;
      else if (went_left) went_left = 1'b0;
      if (steer_angle != want_angle) begin
        put_angle(steer_angle);
        want_angle = steer_angle;
      end
    end else begin
      avoiding = 1'b0;
    end
    stop_or_apply(front, rear);
  endfunction

  function automatic result_t predict_request(logic [1:0] act, logic [87:0] data);
    cmd_t value;
    value  = data[8:0];
    issued = '0;
    case (act)
      ACT_SPEED: want_speed = value;
      ACT_ANGLE: begin
        want_angle = value;
        if (!avoiding) begin
          put_angle(value);
          steer_angle = value;
        end
      end
      ACT_TICK: control_tick(data[24:9], data[40:25], data[56:41], data[72:57], data[81:73]);
      default: ;
    endcase
    issued.obstacle_flag  = avoiding;
    issued.collision_flag = halted;
    return issued;
  endfunction

  function automatic void compare_field(string field, logic signed [31:0] want,
                                        logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      error_total++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (!rst_n) begin
      safe_mm     = SAFE_RESET;
      stop_mm     = STOP_RESET;
      want_speed  = '0;
      drive_speed = '0;
      want_angle  = '0;
      steer_angle = '0;
      ref_heading = '0;
      avoiding    = 1'b0;
      halted      = 1'b0;
      went_right  = 1'b0;
      went_left   = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SAFE) safe_mm = cfg_data;
        else stop_mm = cfg_data;
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_request(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[21:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: result expected none got %h", $time, out_tdata);
          error_total++;
        end else begin
          want = expected_results.pop_front();
          compare_field("speed_issued", want.speed_issued, got.speed_issued);
          compare_field("speed_command", want.speed_command, got.speed_command);
          compare_field("angle_issued", want.angle_issued, got.angle_issued);
          compare_field("angle_command", want.angle_command, got.angle_command);
          compare_field("obstacle_flag", want.obstacle_flag, got.obstacle_flag);
          compare_field("collision_flag", want.collision_flag, got.collision_flag);
        end
      end
    end
    outstanding <= expected_results.size();
    mismatches  <= error_total;
  end

endmodule

[sim/obstacle_avoidance_controller_unit_test.sv]
`timescale 1ns / 1ps
// Testbench top for obstacle_avoidance_controller_unit: directed and random requests
// under several limit settings and idle patterns; verdict from the checker's count.
// Depends on oac_pkg, the block and obstacle_avoidance_controller_unit_checker.
module obstacle_avoidance_controller_unit_test;
  import oac_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         LATENCY    = 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  int          outstanding;
  int          mismatches;

  int send_idle_pct = 34;
  int recv_idle_pct = 85;
  int cur_safe = 0;
  int cur_stop = 400;
  int heading_now = 0;
  int drift = 1;

  obstacle_avoidance_controller_unit dut (.*);
  obstacle_avoidance_controller_unit_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  initial begin
    #2_000_000;
    $display("obstacle_avoidance_controller_unit_test: FAIL");
    $finish;
  end

  task automatic send_request(logic [1:0] act, cmd_t value, range_t front, range_t left,
                              range_t right, range_t rear, heading_t hd);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {6'b0, hd, rear, right, left, front, value};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_cmd(logic [1:0] act, cmd_t value);
    send_request(act, value, range_t'($urandom), range_t'($urandom), range_t'($urandom),
                 range_t'($urandom), heading_t'($urandom));
  endtask

  task automatic send_tick(range_t front, range_t left, range_t right, range_t rear,
                           heading_t hd);
    send_request(ACT_TICK, cmd_t'($urandom), front, left, right, rear, hd);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_limits(int safe, int stop);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SAFE;
    cfg_data  <= safe[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_STOP;
    cfg_data  <= stop[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_safe = safe;
    cur_stop = stop;
  endtask

  // ranges biased around the current thresholds; zero means no echo
  function automatic range_t pick_range(int clear_pct, int close_pct);
    int roll;
    int hi;
    int v;
    roll = $urandom_range(0, 99);
    hi   = (cur_safe > cur_stop) ? cur_safe : cur_stop;
    if (roll < clear_pct)
      return ($urandom_range(0, 7) == 0) ? range_t'(0) : range_t'($urandom_range(hi, 65535));
    if (roll < clear_pct + close_pct)
      return range_t'($urandom_range(0, (hi > 0) ? hi - 1 : 0));
    if (roll < clear_pct + close_pct + 10) begin
      v = (($urandom_range(0, 1) == 0) ? cur_safe : cur_stop) + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return range_t'(v);
    end
    return range_t'($urandom);
  endfunction

  // drifting heading so that turns can reach their targets
  function automatic heading_t next_heading();
    int h;
    if ($urandom_range(0, 19) == 0) begin
      heading_now = int'($urandom_range(0, 511));
    end else begin
      if ($urandom_range(0, 9) == 0) drift = -drift;
      h = heading_now + drift * int'($urandom_range(0, 12));
      if (h < 0) h += 360;
      if (h >= 360) h -= 360;
      heading_now = h;
    end
    return heading_t'(heading_now);
  endfunction

  task automatic send_random_item();
    int   roll;
    cmd_t value;
    roll  = $urandom_range(0, 99);
    value = cmd_t'($urandom_range(0, 180));
    if ($urandom_range(0, 2) == 0) value = -value;
    if ($urandom_range(0, 9) == 0) value = cmd_t'($urandom);
    if (roll < 6) send_cmd(ACT_UNUSED, cmd_t'($urandom));
    else if (roll < 18) send_cmd(ACT_SPEED, value);
    else if (roll < 30) send_cmd(ACT_ANGLE, value);
    else send_tick(pick_range(40, 45), pick_range(50, 35), pick_range(50, 35),
                   pick_range(50, 35), next_heading());
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int safe, int stop);
    wait_drained();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_limits(safe, stop);
    for (int n = 0; n < 112; n++) begin
      if (n == 56) wait_drained();
      send_random_item();
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_limits(800, 300);

    send_cmd(ACT_UNUSED, 9'h1FF);
    send_tick(0, 0, 0, 0, 0);
    send_cmd(ACT_ANGLE, -9'sd180);
    send_cmd(ACT_ANGLE, 9'sd180);
    send_cmd(ACT_ANGLE, 9'sd255);
    send_cmd(ACT_ANGLE, cmd_t'(9'h100));
    send_cmd(ACT_SPEED, 9'sd100);
    send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd10);
    send_tick(500, 100, 0, 0, 9'd10);
    send_cmd(ACT_ANGLE, 9'sd20);
    send_tick(500, 100, 0, 0, 9'd30);
    send_tick(0, 100, 900, 0, 9'd56);
    send_tick(2000, 0, 900, 0, 9'd60);
    send_tick(500, 1000, 100, 0, 9'd300);
    send_tick(500, 1000, 100, 0, 9'd250);
    send_tick(2000, 1000, 16'hFFFF, 0, 9'd0);
    send_tick(200, 200, 200, 0, 9'd0);
    send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd359);
    send_cmd(ACT_SPEED, -9'sd50);
    send_tick(16'hFFFF, 0, 0, 0, 9'd359);
    send_tick(16'hFFFF, 0, 0, 100, 9'd359);
    send_tick(16'hFFFF, 0, 0, 16'hFFFF, 9'd511);
    send_tick(16'hFFFF, 0, 0, 0, 9'd511);
    send_cmd(ACT_SPEED, cmd_t'(9'h100));
    send_cmd(ACT_SPEED, 9'sd255);

    run_phase(34, 85, 800, 300);
    run_phase(34, 85, 0, 400);
    run_phase(85, 34, 65535, 65535);
    run_phase(85, 34, 0, 0);
    run_phase(0, 0, 1500, 200);
    run_phase(0, 0, 300, 1000);
    wait_drained();

    if (mismatches == 0) begin
      $display("obstacle_avoidance_controller_unit_test: PASS");
    end else begin
      $display("obstacle_avoidance_controller_unit_test: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/oac_pkg.sv
sv/oac_core.sv
sv/obstacle_avoidance_controller_unit.sv
sim/obstacle_avoidance_controller_unit_checker.sv
sim/obstacle_avoidance_controller_unit_test.sv
